### rtl/core/md5sh_pkg.sv
// Shared types, constants and round tables of the MD5 stream hasher.
package md5sh_pkg;

   typedef struct packed {
      logic [31:0] data_word;
      logic [2:0]  valid_bytes;
      logic        end_of_message;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [1:0]  word_index;
      logic        last_word;
   } rsp_payload_type;

   localparam logic [31:0] INIT_A = 32'h67452301;
   localparam logic [31:0] INIT_B = 32'hefcdab89;
   localparam logic [31:0] INIT_C = 32'h98badcfe;
   localparam logic [31:0] INIT_D = 32'h10325476;
   localparam logic [7:0]  PAD_BYTE = 8'h80;

   function automatic logic [31:0] round_const(input logic [5:0] r);
      logic [31:0] k;
      unique case (r)
         6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
         6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
         6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
         6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
         6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
         6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
         6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
         6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
         6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
         6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
         6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
         6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
         6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
         6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
         6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
         6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
         6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
         6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
         6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
         6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
         6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
         6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
         6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
      endcase
      return k;
   endfunction

   function automatic logic [4:0] rot_amount(input logic [3:0] idx);
      logic [4:0] s;
      unique case (idx)
         4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
         4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
         4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
         4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
      endcase
      return s;
   endfunction

   // message word used in round r
   function automatic logic [3:0] msg_index(input logic [5:0] r);
      logic [3:0] g;
      unique case (r[5:4])
         2'd0: g = r[3:0];
         2'd1: g = 4'(5 * r[3:0] + 1);
         2'd2: g = 4'(3 * r[3:0] + 5);
         default: g = 4'(7 * r[3:0]);
      endcase
      return g;
   endfunction

endpackage

### rtl/core/md5sh_ram.sv
// Generic single-port write, single-port registered-read RAM.
module md5sh_ram #(
   parameter int Width = 32,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

### rtl/core/md5_stream_hasher.sv
// MD5 stream hasher: byte packing, padding, round sequencer and digest output.
// Usage:
//  req_ channel carries message words (up to four bytes, first byte in 7:0),
//  valid_bytes and end_of_message. rsp_ channel returns the four digest words
//  A..D in order, last_word set on D, after the word marked end_of_message.
//  A req_ transfer is taken in idle; its bytes go into the block one per
//  cycle (paused while a full block is compressed), then a closing step.
//  When a block fills, the compression runs one round per cycle through a
//  single round datapath: a read-ahead step, 64 rounds and a fold into
//  the chaining words.
//  On the final word the padding bytes are also placed one per cycle (9 to
//  72 more bytes), pausing while each of the one or two blocks is compressed.
//  req_stall is high whenever an item is in work; one item at a time.
//  Digest words sit in an output register; a stalled rsp_ holds them and the
//  block waits. Unstalled, A..D leave back to back. After D is taken, the
//  chaining words, counts and pad position return to their initial values.
//  Reset (synchronous) restores the chaining words and clears the counts;
//  the block buffer needs no clearing, since each word is cleared as its
//  first byte lane is written.
module md5_stream_hasher (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  md5sh_pkg::req_payload_type   req_payload,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output md5sh_pkg::rsp_payload_type   rsp_payload
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_BYTES = 5'b00010,
      ST_PAD   = 5'b00100,
      ST_ROUND = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   state_type   state_ff, state_in;
   logic [31:0] word_ff, word_in;
   logic [2:0]  nbytes_ff, nbytes_in;
   logic [2:0]  bidx_ff, bidx_in;
   logic        eom_ff, eom_in;
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] len_ff, len_in;
   logic [63:0] len_snap_ff, len_snap_in;
   logic [3:0]  pad_pos_ff, pad_pos_in; // 0 = 0x80, 1 = zeros, 2.. = length bytes
   logic [31:0] acc_ff, acc_in;     // block word under construction
   logic [31:0] h_ff [4];
   logic [31:0] h_in [4];
   logic [31:0] a_ff, b_ff, c_ff, d_ff, a_in, b_in, c_in, d_in;
   logic [6:0]  rnd_ff, rnd_in;     // 0: prefetch, 1..64: rounds, 65: fold
   logic [1:0]  oidx_ff, oidx_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic        wr_en;
   logic [3:0]  wr_addr, rd_addr;
   logic [31:0] wr_data, rd_data;

   md5sh_ram #(.Width(32), .Depth(16)) u_block_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   logic [7:0]  cur_byte;
   logic        place;
   logic        pad_done;
   logic [31:0] f_val, sum, rot;
   logic [5:0]  r6;
   logic [4:0]  sh;
   logic [63:0] len_shift;

   always_comb begin
      r6 = rnd_ff[5:0] - 6'd1;
      unique case (r6[5:4])
         2'd0: f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         2'd1: f_val = (d_ff & b_ff) | (~d_ff & c_ff);
         2'd2: f_val = b_ff ^ c_ff ^ d_ff;
         default: f_val = c_ff ^ (b_ff | ~d_ff);
      endcase
      sum = a_ff + f_val + md5sh_pkg::round_const(r6) + rd_data;
      sh  = md5sh_pkg::rot_amount({r6[5:4], r6[1:0]});
      rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
      len_shift = len_snap_ff >> {pad_pos_ff[2:0] - 3'd2, 3'b000};
   end

   always_comb begin
      state_in     = state_ff;
      word_in      = word_ff;
      nbytes_in    = nbytes_ff;
      bidx_in      = bidx_ff;
      eom_in       = eom_ff;
      fill_in      = fill_ff;
      len_in       = len_ff;
      len_snap_in  = len_snap_ff;
      pad_pos_in   = pad_pos_ff;
      acc_in       = acc_ff;
      for (int i = 0; i < 4; i++) h_in[i] = h_ff[i];
      a_in = a_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff;
      rnd_in       = rnd_ff;
      oidx_in      = oidx_ff;
      rsp_valid_in = rsp_valid_ff;
      cur_byte     = 8'h00;
      place        = 1'b0;
      pad_done     = 1'b0;
      rd_addr      = 4'd0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               word_in   = req_payload.data_word;
               nbytes_in = (req_payload.valid_bytes > 3'd4) ? 3'd4 : req_payload.valid_bytes;
               eom_in    = req_payload.end_of_message;
               bidx_in   = 3'd0;
               state_in  = ST_BYTES;
            end
         end
         ST_BYTES: begin
            if (bidx_ff == nbytes_ff) begin
               if (eom_ff) begin
                  len_snap_in = len_ff;
                  pad_pos_in  = 4'd0;
                  state_in    = ST_PAD;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               cur_byte = word_ff[{bidx_ff[1:0], 3'b000} +: 8];
               place    = 1'b1;
               bidx_in  = bidx_ff + 3'd1;
               len_in   = len_ff + 64'd8;
            end
         end
         ST_PAD: begin
            place = 1'b1;
            priority if (pad_pos_ff == 4'd0) begin
               cur_byte   = md5sh_pkg::PAD_BYTE;
               pad_pos_in = (fill_ff == 6'd55) ? 4'd2 : 4'd1;
            end else if (pad_pos_ff == 4'd1) begin
               cur_byte = 8'h00;
               if (fill_ff == 6'd55) pad_pos_in = 4'd2;
            end else begin
               cur_byte   = len_shift[7:0];
               pad_pos_in = pad_pos_ff + 4'd1;
               pad_done   = (pad_pos_ff == 4'd9);
            end
         end
         ST_ROUND: begin
            rd_addr = md5sh_pkg::msg_index(rnd_ff[5:0]);
            if (rnd_ff == 7'd0) begin
               a_in = h_ff[0]; b_in = h_ff[1]; c_in = h_ff[2]; d_in = h_ff[3];
               rnd_in = 7'd1;
            end else if (rnd_ff <= 7'd64) begin
               a_in = d_ff; d_in = c_ff; c_in = b_ff; b_in = b_ff + rot;
               rnd_in = rnd_ff + 7'd1;
            end else begin
               h_in[0] = h_ff[0] + a_ff;
               h_in[1] = h_ff[1] + b_ff;
               h_in[2] = h_ff[2] + c_ff;
               h_in[3] = h_ff[3] + d_ff;
               // pad position stays 0 until the first pad byte is placed
               if (eom_ff && pad_pos_ff == 4'd10) begin
                  oidx_in      = 2'd0;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_OUT;
               end else if (pad_pos_ff != 4'd0) begin
                  state_in = ST_PAD;
               end else begin
                  state_in = ST_BYTES;
               end
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               oidx_in = oidx_ff + 2'd1;
               if (oidx_ff == 2'd3) begin
                  rsp_valid_in = 1'b0;
                  h_in[0] = md5sh_pkg::INIT_A;
                  h_in[1] = md5sh_pkg::INIT_B;
                  h_in[2] = md5sh_pkg::INIT_C;
                  h_in[3] = md5sh_pkg::INIT_D;
                  fill_in    = 6'd0;
                  len_in     = 64'd0;
                  pad_pos_in = 4'd0;
                  state_in   = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      wr_en   = 1'b0;
      wr_addr = fill_ff[5:2];
      wr_data = 32'h0;
      if (place) begin
         // clear on lane 0, else merge into the word being built
         unique case (fill_ff[1:0])
            2'd0: wr_data = {24'h0, cur_byte};
            2'd1: wr_data = {16'h0, cur_byte, acc_ff[7:0]};
            2'd2: wr_data = {8'h0, cur_byte, acc_ff[15:0]};
            default: wr_data = {cur_byte, acc_ff[23:0]};
         endcase
         wr_en   = 1'b1;
         acc_in  = wr_data;
         fill_in = fill_ff + 6'd1;
         if (pad_done) pad_pos_in = 4'd10;
         if (fill_ff == 6'd63) begin
            rnd_in   = 7'd0;
            state_in = ST_ROUND;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= 6'd0;
         len_ff       <= 64'd0;
         rsp_valid_ff <= 1'b0;
         oidx_ff      <= 2'd0;
         h_ff[0]      <= md5sh_pkg::INIT_A;
         h_ff[1]      <= md5sh_pkg::INIT_B;
         h_ff[2]      <= md5sh_pkg::INIT_C;
         h_ff[3]      <= md5sh_pkg::INIT_D;
         eom_ff       <= 1'b0;
         pad_pos_ff   <= 4'd0;
         bidx_ff      <= 3'd0;
         nbytes_ff    <= 3'd0;
         rnd_ff       <= 7'd0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
         oidx_ff      <= oidx_in;
         for (int i = 0; i < 4; i++) h_ff[i] <= h_in[i];
         eom_ff       <= eom_in;
         pad_pos_ff   <= pad_pos_in;
         bidx_ff      <= bidx_in;
         nbytes_ff    <= nbytes_in;
         rnd_ff       <= rnd_in;
      end
      word_ff     <= word_in;
      len_snap_ff <= len_snap_in;
      acc_ff      <= acc_in;
      a_ff <= a_in; b_ff <= b_in; c_ff <= c_in; d_ff <= d_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload.digest_word = h_ff[oidx_ff];
   assign rsp_payload.word_index  = oidx_ff;
   assign rsp_payload.last_word   = (oidx_ff == 2'd3);

   a_out_only_in_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == ST_OUT)
      else $error("result valid outside output state");
   a_round_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROUND |-> rnd_ff <= 7'd65)
      else $error("round counter overran");
   a_block_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && $past(state_ff) != ST_ROUND) |-> fill_ff == 6'd0)
      else $error("compression started with a partial block");
   a_idle_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !rsp_valid)
      else $error("result pending while idle");
endmodule

### dv/md5_stream_hasher_tb.sv
// Self-checking testbench of the MD5 stream hasher with a built-in digest predictor.
`timescale 1ns / 100ps

module tb;

   localparam int STALL_LIMIT = 20000;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   md5sh_pkg::req_payload_type req_payload = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   md5sh_pkg::rsp_payload_type rsp_payload;

   md5_stream_hasher u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload)
   );

   always #5 clock = ~clock;

   // predictor state
   logic [31:0] hash_chain [4];
   logic [31:0] hash_block [16];
   int unsigned hash_fill;
   logic [63:0] hash_bits;

   md5sh_pkg::req_payload_type word_queue [$];
   md5sh_pkg::rsp_payload_type digest_queue [$];
   int  mismatches = 0;
   int  idle_count = 0;
   bit  stimulus_done = 1'b0;
   bit  calm_phase = 1'b0;
   bit  req_taken = 1'b0;

   localparam logic [31:0] ROUND_K [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };
   localparam int ROT_S [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

   function automatic logic [31:0] rotate_left(logic [31:0] x, int s);
      return (x << s) | (x >> (32 - s));
   endfunction

   task automatic restart_hash();
      hash_chain = '{32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476};
      foreach (hash_block[i]) hash_block[i] = '0;
      hash_fill = 0;
      hash_bits = '0;
   endtask

   task automatic compress_block();
      logic [31:0] a, b, c, d, f, t;
      int g;
      a = hash_chain[0]; b = hash_chain[1]; c = hash_chain[2]; d = hash_chain[3];
      for (int r = 0; r < 64; r++) begin
         case (r / 16)
            0: begin f = (b & c) | (~b & d); g = r; end
            1: begin f = (d & b) | (~d & c); g = (5 * r + 1) % 16; end
            2: begin f = b ^ c ^ d; g = (3 * r + 5) % 16; end
            default: begin f = c ^ (b | ~d); g = (7 * r) % 16; end
         endcase
         t = d; d = c; c = b;
         b = b + rotate_left(a + f + ROUND_K[r] + hash_block[g], ROT_S[(r / 16) * 4 + r % 4]);
         a = t;
      end
      hash_chain[0] += a; hash_chain[1] += b; hash_chain[2] += c; hash_chain[3] += d;
   endtask

   task automatic append_byte(logic [7:0] value);
      if (hash_fill % 4 == 0) hash_block[hash_fill / 4] = '0;
      hash_block[hash_fill / 4][(hash_fill % 4) * 8 +: 8] = value;
      hash_fill++;
      if (hash_fill == 64) begin
         compress_block();
         hash_fill = 0;
      end
   endtask

   // absorb one accepted word; queue the digest when it closes a message
   task automatic absorb_word(md5sh_pkg::req_payload_type w);
      int n;
      logic [63:0] len;
      md5sh_pkg::rsp_payload_type r;
      n = (w.valid_bytes > 4) ? 4 : w.valid_bytes;
      for (int i = 0; i < n; i++) begin
         append_byte(w.data_word[i * 8 +: 8]);
         hash_bits += 8;
      end
      if (w.end_of_message) begin
         len = hash_bits;
         append_byte(md5sh_pkg::PAD_BYTE);
         while (hash_fill != 56) append_byte(8'h00);
         for (int i = 0; i < 8; i++) append_byte(len[i * 8 +: 8]);
         for (int i = 0; i < 4; i++) begin
            r.digest_word = hash_chain[i];
            r.word_index  = 2'(i);
            r.last_word   = (i == 3);
            digest_queue = {digest_queue, r};
         end
         restart_hash();
      end
   endtask

   function automatic md5sh_pkg::req_payload_type make_word(logic [31:0] data, int nb, bit eom);
      md5sh_pkg::req_payload_type w;
      w.data_word = data;
      w.valid_bytes = 3'(nb);
      w.end_of_message = eom;
      return w;
   endfunction

   task automatic stash_word(md5sh_pkg::req_payload_type w);
      word_queue = {word_queue, w};
   endtask

   task automatic add_message(int words, bit odd_sizes);
      int nb;
      for (int i = 0; i < words; i++) begin
         nb = odd_sizes ? $urandom_range(0, 7) : 4;
         if (i < words - 1 && nb == 0) nb = 4;
         stash_word(make_word($urandom, nb, i == words - 1));
      end
   endtask

   initial begin
      int words;
      restart_hash();
      // directed: empty message, extremes, short words, empty word mid-message
      stash_word(make_word(32'h0, 0, 1'b1));
      stash_word(make_word(32'hffffffff, 7, 1'b1));
      stash_word(make_word(32'h00000000, 4, 1'b0));
      stash_word(make_word(32'hffffffff, 0, 1'b0));
      stash_word(make_word(32'ha5a5a5a5, 1, 1'b0));
      stash_word(make_word(32'h5a5a5a5a, 2, 1'b0));
      stash_word(make_word(32'hffffffff, 3, 1'b0));
      stash_word(make_word(32'h12345678, 5, 1'b0));
      stash_word(make_word(32'hdeadbeef, 6, 1'b1));
      // 56, 55 and 64 bytes: pad needs an extra block, pad fits exactly, pad fills a block of its own
      for (int i = 0; i < 14; i++) stash_word(make_word($urandom, 4, 1'b0));
      stash_word(make_word($urandom, 0, 1'b1));
      add_message(14, 1'b0);
      word_queue[$].valid_bytes = 3'd3;
      add_message(16, 1'b0);
      // random messages, mostly short with some spanning several blocks
      while (word_queue.size() < 450) begin
         words = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 18);
         add_message(words, $urandom_range(0, 1));
      end
   end

   // hold reset, then release it
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   always @(negedge clock) begin
      if (!reset) calm_phase <= ($urandom_range(0, 999) < 5) ? ~calm_phase : calm_phase;
   end

   // driver: hold a word until its transfer, then present the next one
   always @(negedge clock) begin
      if (!reset && !(req_valid && !req_taken)) begin
         if (word_queue.size() > 0 && (calm_phase || $urandom_range(0, 99) >= 6)) begin
            req_payload <= word_queue[0];
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= !calm_phase && $urandom_range(0, 99) < 6;
   end

   // monitor
   always @(posedge clock) begin
      md5sh_pkg::rsp_payload_type exp_word;
      bit moved;
      moved = 1'b0;
      if (!reset) begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            absorb_word(word_queue.pop_front());
            moved = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            if (digest_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected digest word %h", rsp_payload);
            end else begin
               exp_word = digest_queue.pop_front();
               if (rsp_payload !== exp_word) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("digest mismatch: expected %h/%0d/%0d got %h/%0d/%0d",
                              exp_word.digest_word, exp_word.word_index, exp_word.last_word,
                              rsp_payload.digest_word, rsp_payload.word_index,
                              rsp_payload.last_word);
               end
            end
         end
         idle_count <= moved ? 0 : idle_count + 1;
         if (idle_count >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin
      @(negedge reset);
      wait (word_queue.size() == 0 && !req_valid && digest_queue.size() == 0);
      repeat (400) @(posedge clock);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
